// File: src/hsd_pkg.sv
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared constants, codes and types of the Huffman stream decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int DEF_MAX_NODES   = 512;
  localparam int DEF_STACK_DEPTH = 256;
  localparam int DEF_COUNT_BITS  = 40;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_ONE   = 8'h31;  // '1', leaf marker
  localparam logic [7:0] CH_COMMA = 8'h2C;  // ',', end of header

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NODE_FULL   = 2'd1,
    ST_STACK_FULL  = 2'd2,
    ST_BAD_DIGIT   = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    P_HEADER  = 6'b000001,
    P_TREE    = 6'b000010,
    P_LEAFSYM = 6'b000100,
    P_SEP     = 6'b001000,
    P_DATA    = 6'b010000,
    P_DONE    = 6'b100000
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_TOPLOAD  = 5'b00010,
    S_ROOTLOAD = 5'b00100,
    S_WALK     = 5'b01000,
    S_FLUSH    = 5'b10000
  } state_t;

endpackage

// File: src/hsd_in_if.sv
// ----------------------------------------------------------------------------
// hsd_in_if
// Byte input channel: valid/ready with file byte and restart flag.
// ----------------------------------------------------------------------------
interface hsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       start_of_file;

  modport source (output valid, output in_byte, output start_of_file, input ready);
  modport sink   (input valid, input in_byte, input start_of_file, output ready);
endinterface

// File: src/hsd_out_if.sv
// ----------------------------------------------------------------------------
// hsd_out_if
// Result channel: valid/ready with decoded symbol and status.
// ----------------------------------------------------------------------------
interface hsd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       symbol_valid;
  logic       end_of_file;
  logic       last_in_run;
  logic [1:0] status;

  modport source (output valid, output symbol, output symbol_valid, output end_of_file,
                  output last_in_run, output status, input ready);
  modport sink   (input valid, input symbol, input symbol_valid, input end_of_file,
                  input last_in_run, input status, output ready);
endinterface

// File: src/hsd_node_mem.sv
// ----------------------------------------------------------------------------
// hsd_node_mem
// Node table: kind/symbol, left child and right child arrays, one
// registered read port shared by all three.
// ----------------------------------------------------------------------------
module hsd_node_mem #(
  parameter int MAX_NODES = hsd_pkg::DEF_MAX_NODES,
  localparam int NB = $clog2(MAX_NODES)
) (
  input  logic          clk,
  input  logic          kind_we,
  input  logic [NB-1:0] kind_addr,
  input  logic          kind_leaf,
  input  logic [7:0]    kind_sym,
  input  logic          left_we,
  input  logic          right_we,
  input  logic [NB-1:0] par_addr,
  input  logic [NB-1:0] child,
  input  logic          rd_en,
  input  logic [NB-1:0] rd_addr,
  output logic          rd_leaf,
  output logic [7:0]    rd_sym,
  output logic [NB-1:0] rd_left,
  output logic [NB-1:0] rd_right
);

  logic [8:0]    kind_mem  [MAX_NODES];
  logic [NB-1:0] left_mem  [MAX_NODES];
  logic [NB-1:0] right_mem [MAX_NODES];

  always_ff @(posedge clk) begin
    if (kind_we) begin
      kind_mem[kind_addr] <= {kind_leaf, kind_sym};
    end
    if (left_we) begin
      left_mem[par_addr] <= child;
    end
    if (right_we) begin
      right_mem[par_addr] <= child;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      {rd_leaf, rd_sym} <= kind_mem[rd_addr];
      rd_left           <= left_mem[rd_addr];
      rd_right          <= right_mem[rd_addr];
    end
  end

endmodule

// File: src/huffman_stream_decoder.sv
// ----------------------------------------------------------------------------
// huffman_stream_decoder
// Parses a compressed file byte by byte: decimal symbol count, preorder
// tree description, one separator byte, then data bits walked MSB first.
//
//   channel  dir  beat contents
//   din      in   in_byte, start_of_file
//   dout     out  symbol, symbol_valid, end_of_file, last_in_run, status
//
// Header and tree bytes are taken in S_IDLE; a leaf that pops back to a parent
// below the top adds a stack read (S_TOPLOAD), a separator before data a root
// fetch (S_ROOTLOAD). Data bytes walk the node table one bit per cycle while
// the output register has room: accept, 8 bits, end check, flush, and a leaf
// check if the last bit lands on a leaf; the end of the count cuts a byte short.
// Reset is synchronous; a beat with start_of_file restarts parsing.
// A full output register stalls the bit walk; din is held off meanwhile.
// ----------------------------------------------------------------------------
module huffman_stream_decoder #(
  parameter int MAX_NODES   = hsd_pkg::DEF_MAX_NODES,
  parameter int STACK_DEPTH = hsd_pkg::DEF_STACK_DEPTH,
  parameter int COUNT_BITS  = hsd_pkg::DEF_COUNT_BITS
) (
  input  logic clk,
  input  logic rst,
  hsd_in_if.sink    din,
  hsd_out_if.source dout
);
  import hsd_pkg::*;

  localparam int NB = $clog2(MAX_NODES);
  localparam int FW = $clog2(MAX_NODES + 1);
  localparam int SB = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);

  state_t               state;
  phase_t               phase;
  logic [COUNT_BITS-1:0] left_cnt;
  logic [FW-1:0]        nfree;
  logic [LW-1:0]        level;
  logic [NB-1:0]        top_node;
  logic                 top_asg;
  logic [9:0]           stack_mem [STACK_DEPTH];
  logic [9:0]           stack_rd;

  // root entry cache and walk position
  logic                 root_leaf;
  logic [7:0]           root_sym;
  logic [NB-1:0]        root_left, root_right;
  logic                 at_root;
  logic [7:0]           sh;
  logic [3:0]           bits_left;

  // staged symbol, held until we know whether it closes the byte
  logic                 pend_valid;
  logic [7:0]           pend_sym;
  logic                 pend_eof;

  // output register
  logic                 ov;
  logic [7:0]           osym;
  logic                 osv, oeof, olast;
  status_t              ostat;

  // node table port
  logic                 rd_leaf;
  logic [7:0]           rd_sym;
  logic [NB-1:0]        rd_left, rd_right;
  logic                 rd_en;
  logic [NB-1:0]        rd_addr;
  logic                 kind_we, left_we, right_we;

  logic out_free, acc;
  phase_t eff_phase;
  logic [COUNT_BITS-1:0] eff_left, hdr_next;
  logic is_digit;

  // tree build
  logic build, bleaf, full, stk_err, has_par, pop, push_wr;
  logic [LW-1:0] lvl1;
  logic [NB-1:0] n_new;

  // walk
  logic walk_go, chk, root_emit, emit, eof_hit, step_bit, use_root;
  logic [NB-1:0] e_left, e_right, child;
  logic [7:0] emit_sym;

  assign out_free  = !ov || dout.ready;
  assign din.ready = (state == S_IDLE) && out_free;
  assign acc       = din.valid && din.ready;

  assign eff_phase = din.start_of_file ? P_HEADER : phase;
  assign eff_left  = din.start_of_file ? '0 : left_cnt;
  assign is_digit  = (din.in_byte >= CH_ZERO) && (din.in_byte <= CH_NINE);
  // count * 10 + digit as two shifted adds, wrapped to the counter width
  assign hdr_next  = (eff_left << 3) + (eff_left << 1)
                   + COUNT_BITS'(din.in_byte - CH_ZERO);

  // --- tree build: one node per accepted inner-node or leaf-symbol beat
  assign bleaf   = (eff_phase == P_LEAFSYM);
  assign build   = acc && (bleaf || (eff_phase == P_TREE && din.in_byte != CH_ONE));
  assign full    = nfree >= FW'(MAX_NODES);
  assign stk_err = !bleaf && (level == LW'(STACK_DEPTH)) && !top_asg;
  assign has_par = level != '0;
  assign pop     = has_par && top_asg;
  assign lvl1    = level - LW'(pop);
  assign n_new   = nfree[NB-1:0];
  // push: the old top goes to memory when it stays on the stack
  assign push_wr = !bleaf && !pop && has_par;

  assign kind_we  = build && !full && !stk_err;
  assign left_we  = kind_we && has_par && !top_asg;
  assign right_we = kind_we && pop;

  // --- data walk: one bit per cycle while the output register has room
  assign walk_go   = (state == S_WALK) && out_free;
  assign chk       = !at_root && rd_leaf;
  assign use_root  = at_root || chk;
  assign e_left    = use_root ? root_left  : rd_left;
  assign e_right   = use_root ? root_right : rd_right;
  assign root_emit = (bits_left != '0) && at_root && root_leaf;
  assign emit      = chk || root_emit;
  assign emit_sym  = chk ? rd_sym : root_sym;
  assign eof_hit   = left_cnt == COUNT_BITS'(1);
  assign step_bit  = (bits_left != '0) && !(emit && eof_hit);
  assign child     = sh[7] ? e_right : e_left;

  assign rd_en   = (acc && eff_phase == P_SEP) || (walk_go && step_bit && !root_emit);
  assign rd_addr = (state == S_WALK) ? child : '0;

  hsd_node_mem #(.MAX_NODES(MAX_NODES)) u_nodes (
    .clk       (clk),
    .kind_we   (kind_we),
    .kind_addr (n_new),
    .kind_leaf (bleaf),
    .kind_sym  (din.in_byte),
    .left_we   (left_we),
    .right_we  (right_we),
    .par_addr  (top_node),
    .child     (n_new),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_leaf   (rd_leaf),
    .rd_sym    (rd_sym),
    .rd_left   (rd_left),
    .rd_right  (rd_right)
  );

  // build stack below the cached top entry
  always_ff @(posedge clk) begin
    if (kind_we && push_wr) begin
      stack_mem[SB'(lvl1 - LW'(1))] <= {1'b1, 9'(top_node)};
    end
    if (kind_we && bleaf && pop && lvl1 != '0) begin
      stack_rd <= stack_mem[SB'(lvl1 - LW'(1))];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= P_HEADER;
      left_cnt   <= '0;
      nfree      <= '0;
      level      <= '0;
      top_asg    <= 1'b0;
      at_root    <= 1'b1;
      pend_valid <= 1'b0;
      ov         <= 1'b0;
      bits_left  <= '0;
    end else begin
      if (ov && dout.ready) begin
        ov <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (acc) begin
            case (eff_phase)
              P_HEADER: begin
                nfree   <= '0;
                level   <= '0;
                top_asg <= 1'b0;
                at_root <= 1'b1;
                phase   <= P_HEADER;
                left_cnt <= eff_left;
                if (din.in_byte == CH_COMMA) begin
                  phase <= P_TREE;
                end else if (is_digit) begin
                  left_cnt <= hdr_next;
                end else begin
                  ov    <= 1'b1;
                  osym  <= '0;
                  osv   <= 1'b0;
                  oeof  <= 1'b0;
                  olast <= 1'b1;
                  ostat <= ST_BAD_DIGIT;
                end
              end
              P_TREE, P_LEAFSYM: begin
                if (!build) begin
                  phase <= P_LEAFSYM;   // leaf marker, symbol byte follows
                end else if (full || stk_err) begin
                  phase <= P_DONE;
                  ov    <= 1'b1;
                  osym  <= '0;
                  osv   <= 1'b0;
                  oeof  <= 1'b0;
                  olast <= 1'b1;
                  ostat <= full ? ST_NODE_FULL : ST_STACK_FULL;
                end else begin
                  nfree <= nfree + FW'(1);
                  phase <= P_TREE;
                  if (has_par && !top_asg) begin
                    top_asg <= 1'b1;
                  end
                  if (!bleaf) begin
                    top_node <= n_new;
                    top_asg  <= 1'b0;
                    level    <= lvl1 + LW'(1);
                  end else begin
                    level <= lvl1;
                    if (lvl1 == '0) begin
                      phase <= P_SEP;
                    end else if (pop) begin
                      state <= S_TOPLOAD;
                    end
                  end
                end
              end
              P_SEP: begin
                at_root <= 1'b1;
                if (left_cnt == '0) begin
                  phase <= P_DONE;
                end else begin
                  phase <= P_DATA;
                  state <= S_ROOTLOAD;
                end
              end
              P_DATA: begin
                sh        <= din.in_byte;
                bits_left <= BITS_PER_BYTE;
                state     <= S_WALK;
              end
              default: begin
                // finished or halted: drop the byte
              end
            endcase
          end
        end

        S_TOPLOAD: begin
          top_node <= stack_rd[NB-1:0];
          top_asg  <= stack_rd[9];
          state    <= S_IDLE;
        end

        S_ROOTLOAD: begin
          root_leaf  <= rd_leaf;
          root_sym   <= rd_sym;
          root_left  <= rd_left;
          root_right <= rd_right;
          state      <= S_IDLE;
        end

        S_WALK: begin
          if (walk_go) begin
            if (chk) begin
              at_root <= 1'b1;
            end
            if (step_bit) begin
              sh        <= {sh[6:0], 1'b0};
              bits_left <= bits_left - 4'd1;
              if (!root_emit) begin
                at_root <= 1'b0;
              end
            end
            if (emit) begin
              left_cnt   <= left_cnt - COUNT_BITS'(1);
              pend_valid <= 1'b1;
              pend_sym   <= emit_sym;
              pend_eof   <= eof_hit;
              if (pend_valid) begin
                ov    <= 1'b1;
                osym  <= pend_sym;
                osv   <= 1'b1;
                oeof  <= pend_eof;
                olast <= 1'b0;
                ostat <= ST_OK;
              end
              if (eof_hit) begin
                phase   <= P_DONE;
                state   <= S_FLUSH;
                at_root <= 1'b1;
              end
            end
            if (bits_left == '0 && !chk) begin
              state <= S_FLUSH;
            end
          end
        end

        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            ov         <= 1'b1;
            osym       <= pend_sym;
            osv        <= 1'b1;
            oeof       <= pend_eof;
            olast      <= 1'b1;
            ostat      <= ST_OK;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign dout.valid        = ov;
  assign dout.symbol       = osym;
  assign dout.symbol_valid = osv;
  assign dout.end_of_file  = oeof;
  assign dout.last_in_run  = olast;
  assign dout.status       = ostat;

endmodule

// File: verif/huffman_stream_decoder_tb.sv
// ----------------------------------------------------------------------------
// huffman_stream_decoder_tb
// Self-checking bench for the Huffman stream decoder: builds compressed files
// (count header, preorder tree, separator, data), predicts every decoded beat
// with a cycle-free model of the parser and compares field by field.
// ----------------------------------------------------------------------------
module huffman_stream_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hsd_pkg::*;

  localparam int NODES = DEF_MAX_NODES;
  localparam int DEPTH = DEF_STACK_DEPTH;
  localparam int CBITS = DEF_COUNT_BITS;
  localparam int CALM_TAIL = 60;  // last beats are driven with no idling

  typedef struct {
    logic [7:0] data;
    logic       sof;
    bit         drain;  // hold this beat until every decoded symbol is back
  } file_byte_t;

  typedef struct {
    logic [7:0] symbol;
    logic       symbol_valid;
    logic       end_of_file;
    logic       last_in_run;
    status_t    status;
  } decoded_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  hsd_in_if  din_if ();
  hsd_out_if dout_if ();

  huffman_stream_decoder i_dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_if),
    .dout (dout_if)
  );

  always #10 clk = ~clk;

  file_byte_t byte_q[$];
  decoded_t   decoded_q[$];
  int         mismatches = 0;
  int unsigned n_sent = 0;
  int unsigned n_taken = 0;

  // --------------------------------------------------------------------------
  // Parser shadow state
  // --------------------------------------------------------------------------
  phase_t            sh_phase;
  logic [CBITS-1:0]  sh_left;
  logic [18:0]       sh_nodes[NODES];
  logic [9:0]        sh_stack[DEPTH];
  int unsigned       sh_free;
  int unsigned       sh_level;
  logic [8:0]        sh_cur;

  function automatic void shadow_clear();
    sh_phase = P_HEADER;
    sh_left  = '0;
    sh_free  = 0;
    sh_level = 0;
    sh_cur   = '0;
    foreach (sh_nodes[i]) sh_nodes[i] = '0;
    foreach (sh_stack[i]) sh_stack[i] = '0;
  endfunction

  function automatic void expect_beat(logic [7:0] sym, logic sv, logic eof, logic last,
                                      status_t st);
    decoded_t d;
    d.symbol = sym;
    d.symbol_valid = sv;
    d.end_of_file = eof;
    d.last_in_run = last;
    d.status = st;
    decoded_q.push_back(d);
  endfunction

  // Attach a fresh node under the open parent on top of the build stack.
  function automatic status_t grow_tree(bit is_leaf, logic [7:0] sym);
    int unsigned n;
    logic [9:0]  top;
    logic [8:0]  par;
    if (sh_free >= NODES) return ST_NODE_FULL;
    // a full stack is still fine if this node closes the top parent first
    if (!is_leaf && sh_level >= DEPTH && !sh_stack[DEPTH-1][9]) return ST_STACK_FULL;
    n = sh_free;
    sh_free++;
    sh_nodes[n] = is_leaf ? {1'b1, 10'd0, sym} : 19'd0;
    if (sh_level > 0) begin
      top = sh_stack[sh_level-1];
      par = top[8:0];
      if (!top[9]) begin
        sh_nodes[par][17:9] = n[8:0];
        sh_stack[sh_level-1] = top | 10'h200;
      end else begin
        sh_nodes[par][8:0] = n[8:0];
        sh_level--;
      end
    end
    if (!is_leaf) begin
      if (sh_level >= DEPTH) return ST_STACK_FULL;
      sh_stack[sh_level] = {1'b0, n[8:0]};
      sh_level++;
    end
    if (sh_level == 0) sh_phase = P_SEP;
    return ST_OK;
  endfunction

  // Decode one accepted file byte and queue the beats it should produce.
  function automatic void decode_byte(logic [7:0] b, logic sof);
    status_t     st;
    logic [18:0] v;
    int          found;
    found = 0;
    if (sof) shadow_clear();
    case (sh_phase)
      P_HEADER: begin
        if (b == CH_COMMA) sh_phase = P_TREE;
        else if (b >= CH_ZERO && b <= CH_NINE) sh_left = sh_left * 10 + (b - CH_ZERO);
        else expect_beat(8'd0, 1'b0, 1'b0, 1'b1, ST_BAD_DIGIT);
        return;
      end
      P_TREE: begin
        if (b == CH_ONE) begin
          sh_phase = P_LEAFSYM;
          return;
        end
        st = grow_tree(1'b0, 8'd0);
      end
      P_LEAFSYM: begin
        sh_phase = P_TREE;
        st = grow_tree(1'b1, b);
      end
      P_SEP: begin
        sh_cur = '0;
        sh_phase = (sh_left == 0) ? P_DONE : P_DATA;
        return;
      end
      P_DATA: begin
        for (int i = 7; i >= 0; i--) begin
          v = sh_nodes[sh_cur];
          if (!v[18]) begin
            sh_cur = b[i] ? v[8:0] : v[17:9];
            v = sh_nodes[sh_cur];
            if (!v[18]) continue;
          end
          sh_left = sh_left - 1;
          sh_cur = '0;
          if (sh_left == 0) begin
            expect_beat(v[7:0], 1'b1, 1'b1, 1'b1, ST_OK);
            sh_phase = P_DONE;
            return;
          end
          expect_beat(v[7:0], 1'b1, 1'b0, 1'b0, ST_OK);
          found++;
        end
        if (found > 0) decoded_q[$].last_in_run = 1'b1;
        return;
      end
      default: return;
    endcase
    if (st != ST_OK) begin
      sh_phase = P_DONE;
      expect_beat(8'd0, 1'b0, 1'b0, 1'b1, st);
    end
  endfunction

  // --------------------------------------------------------------------------
  // File builders
  // --------------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] b, logic sof = 1'b0, bit drain = 1'b0);
    file_byte_t f;
    f.data = b;
    f.sof = sof;
    f.drain = drain;
    byte_q.push_back(f);
  endfunction

  function automatic logic [7:0] inner_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_ONE);
    return b;
  endfunction

  function automatic void put_header(string digits, bit drain = 1'b0);
    for (int i = 0; i < digits.len(); i++) put_byte(digits[i], i == 0, drain && i == 0);
    put_byte(CH_COMMA, digits.len() == 0, drain && digits.len() == 0);
  endfunction

  // Preorder description of a random full tree with the given leaf count.
  function automatic void put_tree(int leaves);
    int k;
    logic [7:0] sym;
    if (leaves <= 1) begin
      put_byte(CH_ONE);
      if ($urandom_range(0, 3) == 0) sym = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      else sym = 8'($urandom_range(0, 255));
      put_byte(sym);
    end else begin
      put_byte(inner_byte());
      k = $urandom_range(1, leaves - 1);
      put_tree(k);
      put_tree(leaves - k);
    end
  endfunction

  function automatic void put_file(int count, int leaves, int data_bytes, bit drain = 1'b0);
    put_header($sformatf("%0d", count), drain);
    put_tree(leaves);
    put_byte(8'($urandom_range(0, 255)));  // separator
    repeat (data_bytes) put_byte(8'($urandom_range(0, 255)));
  endfunction

  // --------------------------------------------------------------------------
  // Mismatch reporting and output checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    mismatches++;
    $display("[%0t] decode error: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (!rst && din_if.valid && din_if.ready) begin
      decode_byte(din_if.in_byte, din_if.start_of_file);
      n_taken++;
    end
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat symbol %02h status %0d",
                                  dout_if.symbol, dout_if.status));
      end else begin
        want = decoded_q.pop_front();
        if (dout_if.symbol !== want.symbol)
          report_mismatch($sformatf("symbol %02h, want %02h", dout_if.symbol, want.symbol));
        if (dout_if.symbol_valid !== want.symbol_valid)
          report_mismatch($sformatf("symbol_valid %b, want %b",
                                    dout_if.symbol_valid, want.symbol_valid));
        if (dout_if.end_of_file !== want.end_of_file)
          report_mismatch($sformatf("end_of_file %b, want %b",
                                    dout_if.end_of_file, want.end_of_file));
        if (dout_if.last_in_run !== want.last_in_run)
          report_mismatch($sformatf("last_in_run %b, want %b",
                                    dout_if.last_in_run, want.last_in_run));
        if (dout_if.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", dout_if.status, want.status));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Byte driver and result sink, both switched at the falling edge
  // --------------------------------------------------------------------------
  int unsigned send_gap = 0;
  int unsigned sink_gap = 0;

  initial begin
    din_if.valid = 1'b0;
    din_if.in_byte = '0;
    din_if.start_of_file = 1'b0;
    dout_if.ready = 1'b0;
  end

  always @(negedge clk) begin
    file_byte_t f;
    if (rst) begin
      din_if.valid <= 1'b0;
    end else if (n_sent == n_taken) begin
      // previous beat is gone: idle, hold for drain, or present the next one
      if (send_gap > 0) begin
        send_gap--;
        din_if.valid <= 1'b0;
      end else if (byte_q.size() == 0) begin
        din_if.valid <= 1'b0;
      end else if (byte_q[0].drain && decoded_q.size() != 0) begin
        din_if.valid <= 1'b0;
      end else begin
        f = byte_q.pop_front();
        din_if.valid <= 1'b1;
        din_if.in_byte <= f.data;
        din_if.start_of_file <= f.sof;
        n_sent++;
        if (byte_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
          send_gap = $urandom_range(1, 14);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      dout_if.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      dout_if.ready <= 1'b0;
    end else begin
      dout_if.ready <= 1'b1;
      if (byte_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0)
        sink_gap = $urandom_range(1, 14);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int kind;
    bit drained;
    drained = 1'b0;
    shadow_clear();

    // bad header bytes between digits, extreme byte values
    put_byte(8'h00, 1'b1);
    put_byte("2");
    put_byte(8'hFF);
    put_byte(",");
    put_byte(CH_ONE);
    put_byte(8'h00);
    put_byte(8'hFF);
    // zero count: nothing decoded, halts after the separator
    put_file(0, 2, 2);
    // bare leaf root: one symbol per data bit
    put_header("12");
    put_byte(CH_ONE);
    put_byte(8'hFF);
    put_byte(8'h5A);
    put_byte(8'h00);
    put_byte(8'hFF);
    // count wraps modulo the counter width
    put_file(0, 3, 0);
    put_header("9999999999999");
    put_byte(CH_ONE);
    put_byte(8'h41);
    put_byte(8'h00);
    put_byte(8'h7E);
    // build stack full: a run of internal nodes only
    put_header("3");
    repeat (DEPTH + 1) put_byte(inner_byte());
    put_byte(8'h00);

    // random part: mostly complete files, some noise and truncated files
    while (byte_q.size() < 385) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        put_file($urandom_range(1, 20), $urandom_range(1, 8), $urandom_range(1, 22),
                 !drained && byte_q.size() > 300);
        if (byte_q.size() > 300) drained = 1'b1;
      end else if (kind == 8) begin
        repeat ($urandom_range(2, 6))
          put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        put_header($sformatf("%0d", $urandom_range(1, 30)));
        put_tree($urandom_range(2, 8));
        void'(byte_q.pop_back());
      end
    end
    // finish on a complete file so the calm tail decodes real symbols
    put_file($urandom_range(10, 20), $urandom_range(2, 8), 24);

    repeat (9) @(posedge clk);
    rst <= 1'b1;
    @(negedge clk);
    rst = 1'b0;

    wait (byte_q.size() == 0 && n_sent == n_taken);
    wait (decoded_q.size() == 0);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Give up on a hung run.
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: filelist.f
src/hsd_pkg.sv
src/hsd_in_if.sv
src/hsd_out_if.sv
src/hsd_node_mem.sv
src/huffman_stream_decoder.sv
verif/huffman_stream_decoder_tb.sv
